[src/mrsd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the MIDI running status decoder.
// No dependencies; imported by midi_running_status_decoder_core.
package mrsd_pkg;

    localparam int CHANNEL_COUNT = 16;
    localparam int CHAN_W        = 4;
    localparam int DATA_W        = 7;
    localparam int BEND_W        = 14;
    localparam int PATCH_W       = 8;
    localparam int KIND_W        = 3;
    localparam int OUT_FIELDS_W  = KIND_W + CHAN_W + 2 * DATA_W + BEND_W + PATCH_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [3:0] DRUM_CHANNEL_RESET = 4'd9;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] REALTIME_LO = 8'hF8;
    localparam logic [7:0] NO_STATUS   = 8'h00;

    localparam logic [DATA_W-1:0] NOTE_OFF_VEL = 7'd64;

    typedef enum logic [3:0] {
        ST_NOTE_OFF   = 4'h8,
        ST_NOTE_ON    = 4'h9,
        ST_POLY_AT    = 4'hA,
        ST_CTRL       = 4'hB,
        ST_PROGRAM    = 4'hC,
        ST_CHAN_PRESS = 4'hD,
        ST_PITCH_BEND = 4'hE
    } t_status_kind;

    typedef enum logic [KIND_W-1:0] {
        EV_NOTE_ON    = 3'd0,
        EV_NOTE_OFF   = 3'd1,
        EV_CTRL       = 3'd2,
        EV_PROGRAM    = 3'd3,
        EV_PITCH_BEND = 3'd4
    } t_event_kind;

    typedef struct packed {
        t_event_kind       kind;
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] d1;
        logic [DATA_W-1:0] d2;
        logic              is_drum;
    } t_event;

    function automatic logic [1:0] msg_length(input logic [7:0] status);
        logic [1:0] len;
        unique case (status[7:4])
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_PITCH_BEND: len = 2'd3;
            ST_PROGRAM, ST_CHAN_PRESS:                                  len = 2'd2;
            default:                                                    len = 2'd1;
        endcase
        return len;
    endfunction

endpackage

[src/midi_running_status_decoder_core.sv]
`timescale 1ns / 1ps
// MIDI running status decoder: parses raw bytes into channel events and keeps
// a per-channel program memory. Depends on mrsd_pkg.
//
// Usage:
//   Slave stream (i_s_*): one raw MIDI byte per beat in tdata[7:0].
//   Master stream (o_m_*): one beat per completed note on/off, control
//   change, program change or pitch bend message.
//   Config channel (i_cfg_*): drum channel number; write only while idle.
// Timing:
//   One byte accepted per cycle when not stalled; its event shows on the
//   master side in the cycle after acceptance. Program memory is read in
//   the accept cycle and its registered data forms the output stage.
// Reset (synchronous, active low): parser state cleared, no running status,
//   drum channel 9, all channel programs read as 0 (per-entry valid flags).
// Backpressure: the output stage holds while i_m_tready is low; a new byte is
//   still taken when the output stage is empty or being drained that cycle.
module midi_running_status_decoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,   // [7:0] rx_byte
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [2:0] event_kind, [6:3] chan, [13:7] first_data, [20:14] second_data,
    // [34:21] bend_value, [42:35] patch_number, [47:43] zero
    output logic [mrsd_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mrsd_pkg::CHAN_W-1:0]     i_cfg_data
);
    import mrsd_pkg::*;

    logic [CHAN_W-1:0] r_drum_chan;

    logic              r_sysex;
    logic [7:0]        r_run_status;
    logic [1:0]        r_pos;
    logic [1:0]        r_exp_len;
    logic [7:0]        r_held_status;
    logic [DATA_W-1:0] r_held_d1;

    logic              n_sysex;
    logic [7:0]        n_run_status;
    logic [1:0]        n_pos;
    logic [1:0]        n_exp_len;
    logic [7:0]        n_held_status;
    logic [DATA_W-1:0] n_held_d1;

    logic [DATA_W-1:0]        r_prog_mem [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] r_prog_vld;
    logic [DATA_W-1:0]        r_prog_rd;
    logic                     r_prog_rd_vld;

    logic   r_m_valid;
    t_event r_evt;
    t_event n_evt;
    logic   n_evt_valid;
    logic   n_prog_wr;

    logic s_accept;
    logic advance;

    logic [7:0]        b;
    logic [7:0]        hs_e;
    logic [1:0]        pos_e;
    logic [1:0]        exp_e;
    logic [1:0]        np;
    logic [DATA_W-1:0] d1_e;
    logic [DATA_W-1:0] d2_e;

    logic [PATCH_W-1:0] patch;
    logic [BEND_W-1:0]  bend;
    logic [DATA_W-1:0]  d2_out;
    logic               is_note;

    assign advance    = !r_m_valid || i_m_tready;
    assign o_s_tready = advance;
    assign s_accept   = i_s_tvalid && advance;
    assign o_cfg_ready = 1'b1;
    assign b = i_s_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drum_chan <= DRUM_CHANNEL_RESET;
        end else if (i_cfg_valid) begin
            r_drum_chan <= i_cfg_data;
        end
    end

    always_comb begin
        n_sysex       = r_sysex;
        n_run_status  = r_run_status;
        n_pos         = r_pos;
        n_exp_len     = r_exp_len;
        n_held_status = r_held_status;
        n_held_d1     = r_held_d1;
        n_evt_valid   = 1'b0;
        n_prog_wr     = 1'b0;
        hs_e  = (r_pos == 2'd0) ? r_run_status : r_held_status;
        exp_e = (r_pos == 2'd0) ? msg_length(r_run_status) : r_exp_len;
        pos_e = (r_pos == 2'd0) ? 2'd1 : r_pos;
        np    = (pos_e == 2'd1) ? 2'd2 : 2'd3;
        d1_e  = (pos_e == 2'd1) ? b[DATA_W-1:0] : r_held_d1;
        d2_e  = b[DATA_W-1:0];
        n_evt.kind    = EV_NOTE_ON;
        n_evt.chan    = hs_e[CHAN_W-1:0];
        n_evt.d1      = d1_e;
        n_evt.d2      = d2_e;
        n_evt.is_drum = (hs_e[CHAN_W-1:0] == r_drum_chan);

        priority if (r_sysex) begin
            if (b == SYSEX_END) n_sysex = 1'b0;
        end else if (b[7]) begin
            priority if (b >= REALTIME_LO) begin
                n_sysex = r_sysex;
            end else if (b == SYSEX_START) begin
                n_sysex = 1'b1;
            end else if (b > SYSEX_START) begin
                n_sysex = r_sysex;
            end else begin
                n_run_status  = b;
                n_held_status = b;
                n_pos         = 2'd1;
                n_exp_len     = msg_length(b);
            end
        end else if (r_run_status != NO_STATUS) begin
            n_held_status = hs_e;
            n_exp_len     = exp_e;
            if (pos_e == 2'd1) n_held_d1 = b[DATA_W-1:0];
            if (np < exp_e) begin
                n_pos = np;
            end else begin
                n_pos = 2'd0;
                unique case (hs_e[7:4])
                    ST_NOTE_OFF: begin
                        n_evt.kind  = EV_NOTE_OFF;
                        n_evt_valid = 1'b1;
                    end
                    ST_NOTE_ON: begin
                        if (d2_e == '0) begin
                            n_evt.kind = EV_NOTE_OFF;
                            n_evt.d2   = NOTE_OFF_VEL;
                        end else begin
                            n_evt.kind = EV_NOTE_ON;
                        end
                        n_evt_valid = 1'b1;
                    end
                    ST_CTRL: begin
                        n_evt.kind  = EV_CTRL;
                        n_evt_valid = 1'b1;
                    end
                    ST_PROGRAM: begin
                        n_evt.kind  = EV_PROGRAM;
                        n_evt.d2    = '0;
                        n_evt_valid = 1'b1;
                        n_prog_wr   = 1'b1;
                    end
                    ST_PITCH_BEND: begin
                        n_evt.kind  = EV_PITCH_BEND;
                        n_evt_valid = 1'b1;
                    end
                    default: n_evt_valid = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sysex       <= 1'b0;
            r_run_status  <= NO_STATUS;
            r_pos         <= 2'd0;
            r_exp_len     <= 2'd0;
            r_held_status <= NO_STATUS;
            r_held_d1     <= '0;
        end else if (s_accept) begin
            r_sysex       <= n_sysex;
            r_run_status  <= n_run_status;
            r_pos         <= n_pos;
            r_exp_len     <= n_exp_len;
            r_held_status <= n_held_status;
            r_held_d1     <= n_held_d1;
        end
    end

    // program memory: written on program change, read for every accepted byte
    always_ff @(posedge i_clk) begin
        if (s_accept && n_prog_wr) begin
            r_prog_mem[n_evt.chan] <= n_evt.d1;
        end
        if (advance) begin
            r_prog_rd <= r_prog_mem[n_evt.chan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_vld    <= '0;
            r_prog_rd_vld <= 1'b0;
        end else begin
            if (s_accept && n_prog_wr) r_prog_vld[n_evt.chan] <= 1'b1;
            if (advance) r_prog_rd_vld <= r_prog_vld[n_evt.chan];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (advance) begin
            r_m_valid <= s_accept && n_evt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_evt <= n_evt;
    end

    assign is_note = (r_evt.kind == EV_NOTE_ON) || (r_evt.kind == EV_NOTE_OFF);
    assign d2_out  = r_evt.d2;

    always_comb begin
        patch = '0;
        if (is_note) begin
            if (r_evt.is_drum)      patch = {1'b1, r_evt.d1};
            else if (r_prog_rd_vld) patch = {1'b0, r_prog_rd};
        end
        bend = (r_evt.kind == EV_PITCH_BEND) ? {r_evt.d2, r_evt.d1} : '0;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, patch, bend, d2_out,
                         r_evt.d1, r_evt.chan, r_evt.kind};

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 2'd3)
        else $error("byte position reached an unused value");

    a_sysex_keeps_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_sysex) |=> ($stable(r_run_status) && !r_m_valid))
        else $error("sysex byte changed running status or made an event");

    a_bend_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_evt.kind != EV_PITCH_BEND)) |-> (bend == '0))
        else $error("bend value on a non-bend event");

    a_patch_notes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (patch != '0)) |-> is_note)
        else $error("patch number on a non-note event");
`endif

endmodule
